@@ design/cstr_pkg.sv @@
// ----------------------------------------------------------------------------
// cstr_pkg - shared types and constants for the contrast stretch block
// pixel width, payload structs, opcodes, register indexes, controller codes
// ----------------------------------------------------------------------------
package cstr_pkg;

    // pixel width and derived datapath widths
    localparam int PIX_W  = 8;
    localparam int DIFF_W = PIX_W + 1;          // signed difference of two pixels
    localparam int PROD_W = 2 * DIFF_W;         // signed product of two differences
    localparam int MAG_W  = 2 * PIX_W;          // magnitude of the product
    localparam int CNT_W  = $clog2(MAG_W);      // divider iteration counter

    // opcodes of an input transaction
    typedef enum logic [1:0] {
        OP_CLEAR     = 2'd0,
        OP_MEASURE   = 2'd1,
        OP_NORMALIZE = 2'd2
    } op_t;

    // configuration register indexes
    localparam logic [1:0] REG_RANGE_LOW   = 2'd0;
    localparam logic [1:0] REG_RANGE_HIGH  = 2'd1;
    localparam logic [1:0] REG_TARGET_LOW  = 2'd2;
    localparam logic [1:0] REG_TARGET_HIGH = 2'd3;

    // configuration reset values
    localparam logic [PIX_W-1:0] PIX_ZERO = '0;
    localparam logic [PIX_W-1:0] PIX_FULL = '1;

    // input transaction
    typedef struct packed {
        logic [1:0]       opcode;
        logic [PIX_W-1:0] pixel_in;
    } pix_in_t;

    // result transaction
    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic [PIX_W-1:0] bound_min;
        logic [PIX_W-1:0] bound_max;
        logic             divide_error;
    } res_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_PREP,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic calc;
        logic prep;
        logic div_step;
        logic fix;
        logic load_result;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic normalize_go;
        logic div_last;
        logic res_free;
    } ctrl_stat_t;

endpackage

@@ design/grayscale_min_max_contrast_stretch_top.sv @@
// ----------------------------------------------------------------------------
// grayscale_min_max_contrast_stretch_top - 8-bit grayscale contrast stretch
// running min/max bounds and linear range mapping with a serial divider
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Clear, measure and the unused opcode
// go through the calc step straight to the result load; so does normalize
// with equal source bounds. Normalize otherwise steps through a multiply, a
// step to form magnitudes, the restoring divider (one quotient bit per cycle
// over the 2*PIX_W bit numerator), a step to restore the sign and add
// target_low, and the load of the result register. The result register lets
// the next transaction be taken while a finished result still waits on
// res_stall. Configuration writes are always ready and must only be issued
// while the block is idle.
module grayscale_min_max_contrast_stretch_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // pixel transactions
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  cstr_pkg::pix_in_t                 pix_data,
    // result transactions
    output logic                              res_valid,
    input  logic                              res_stall,
    output cstr_pkg::res_t                    res_data,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [cstr_pkg::PIX_W-1:0]        cfg_data
);

    cstr_pkg::ctrl_cmd_t  cmd;
    cstr_pkg::ctrl_stat_t stat;

    // register file never pushes back
    assign cfg_ready = 1'b1;

    // sequencer: walks calc, divide and result load
    cstr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: config, bounds, multiplier, divider, result register
    cstr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_data  (pix_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_data  (res_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ design/cstr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cstr_ctrl - sequencing state machine
// steps one transaction through calc, divide and result load
// ----------------------------------------------------------------------------
module cstr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  cstr_pkg::ctrl_stat_t  stat,
    output cstr_pkg::ctrl_cmd_t   cmd
);

    cstr_pkg::state_t state_reg;
    cstr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cstr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cstr_pkg::ST_IDLE:
            begin
                if (pix_valid)
                begin
                    state_next = cstr_pkg::ST_CALC;
                end
            end
            cstr_pkg::ST_CALC:
            begin
                state_next = stat.normalize_go ? cstr_pkg::ST_PREP : cstr_pkg::ST_DONE;
            end
            cstr_pkg::ST_PREP:
            begin
                state_next = cstr_pkg::ST_DIV;
            end
            cstr_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = cstr_pkg::ST_FIX;
                end
            end
            cstr_pkg::ST_FIX:
            begin
                state_next = cstr_pkg::ST_DONE;
            end
            cstr_pkg::ST_DONE:
            begin
                if (stat.res_free)
                begin
                    state_next = cstr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cstr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        pix_stall = 1'b1;
        case (state_reg)
            cstr_pkg::ST_IDLE:
            begin
                pix_stall     = 1'b0;
                cmd.load_item = pix_valid;
            end
            cstr_pkg::ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            cstr_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            cstr_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            cstr_pkg::ST_FIX:
            begin
                cmd.fix = 1'b1;
            end
            cstr_pkg::ST_DONE:
            begin
                cmd.load_result = stat.res_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ design/cstr_datapath.sv @@
// ----------------------------------------------------------------------------
// cstr_datapath - registers, bounds, multiplier and restoring divider
// holds configuration, running bounds and the result register
// ----------------------------------------------------------------------------
module cstr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cstr_pkg::pix_in_t                 pix_data,
    input  logic                              cfg_valid,
    input  logic [1:0]                        cfg_index,
    input  logic [cstr_pkg::PIX_W-1:0]        cfg_data,
    input  logic                              res_stall,
    output logic                              res_valid,
    output cstr_pkg::res_t                    res_data,
    input  cstr_pkg::ctrl_cmd_t               cmd,
    output cstr_pkg::ctrl_stat_t              stat
);

    localparam int PIX_W  = cstr_pkg::PIX_W;
    localparam int DIFF_W = cstr_pkg::DIFF_W;
    localparam int PROD_W = cstr_pkg::PROD_W;
    localparam int MAG_W  = cstr_pkg::MAG_W;
    localparam int CNT_W  = cstr_pkg::CNT_W;

    // configuration
    logic [PIX_W-1:0] range_low_reg;
    logic [PIX_W-1:0] range_high_reg;
    logic [PIX_W-1:0] target_low_reg;
    logic [PIX_W-1:0] target_high_reg;

    // running bounds
    logic [PIX_W-1:0] min_reg, min_next;
    logic [PIX_W-1:0] max_reg, max_next;

    // transaction and arithmetic
    cstr_pkg::pix_in_t          item_reg;
    logic                       err_reg, err_next;
    logic [PIX_W-1:0]           pout_reg, pout_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [DIFF_W-1:0]   dvsr_reg, dvsr_next;
    logic                       neg_reg, neg_next;
    logic [MAG_W-1:0]           quo_reg, quo_next;
    logic [PIX_W-1:0]           rem_reg, rem_next;
    logic [PIX_W-1:0]           den_reg, den_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    // result register
    logic                       res_valid_reg, res_valid_next;
    cstr_pkg::res_t             res_reg, res_next;

    logic signed [DIFF_W-1:0]   diff_pix;
    logic signed [DIFF_W-1:0]   diff_tgt;
    logic signed [PROD_W-1:0]   prod_abs;
    logic signed [DIFF_W-1:0]   dvsr_abs;
    logic [PIX_W:0]             trial_rem;
    logic [PIX_W:0]             trial_sub;
    logic [PIX_W-1:0]           quo_low;
    logic                       is_norm;
    logic                       bounds_equal;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg   <= cstr_pkg::PIX_ZERO;
            range_high_reg  <= cstr_pkg::PIX_FULL;
            target_low_reg  <= cstr_pkg::PIX_ZERO;
            target_high_reg <= cstr_pkg::PIX_FULL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cstr_pkg::REG_RANGE_LOW:   range_low_reg   <= cfg_data;
                cstr_pkg::REG_RANGE_HIGH:  range_high_reg  <= cfg_data;
                cstr_pkg::REG_TARGET_LOW:  target_low_reg  <= cfg_data;
                cstr_pkg::REG_TARGET_HIGH: target_high_reg <= cfg_data;
                default:                   range_low_reg   <= range_low_reg;
            endcase
        end
    end

    // control state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= cstr_pkg::PIX_FULL;
            max_reg       <= cstr_pkg::PIX_ZERO;
            res_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            min_reg       <= min_next;
            max_reg       <= max_next;
            res_valid_reg <= res_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= pix_data;
        end
        err_reg  <= err_next;
        pout_reg <= pout_next;
        prod_reg <= prod_next;
        dvsr_reg <= dvsr_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        res_reg  <= res_next;
    end

    assign is_norm      = (item_reg.opcode == cstr_pkg::OP_NORMALIZE);
    assign bounds_equal = (range_high_reg == range_low_reg);

    assign diff_pix  = $signed({1'b0, item_reg.pixel_in}) - $signed({1'b0, range_low_reg});
    assign diff_tgt  = $signed({1'b0, target_high_reg}) - $signed({1'b0, target_low_reg});
    assign prod_abs  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign dvsr_abs  = dvsr_reg[DIFF_W-1] ? -dvsr_reg : dvsr_reg;
    assign trial_rem = {rem_reg, quo_reg[MAG_W-1]};
    assign trial_sub = trial_rem - {1'b0, den_reg};
    assign quo_low   = neg_reg ? (PIX_W'(0) - quo_reg[PIX_W-1:0]) : quo_reg[PIX_W-1:0];

    always_comb
    begin
        min_next       = min_reg;
        max_next       = max_reg;
        err_next       = err_reg;
        pout_next      = pout_reg;
        prod_next      = prod_reg;
        dvsr_next      = dvsr_reg;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;

        if (cmd.calc)
        begin
            // bounds update and default pass-through
            case (item_reg.opcode)
                cstr_pkg::OP_CLEAR:
                begin
                    min_next = cstr_pkg::PIX_FULL;
                    max_next = cstr_pkg::PIX_ZERO;
                end
                cstr_pkg::OP_MEASURE:
                begin
                    if (item_reg.pixel_in < min_reg)
                    begin
                        min_next = item_reg.pixel_in;
                    end
                    if (item_reg.pixel_in > max_reg)
                    begin
                        max_next = item_reg.pixel_in;
                    end
                end
                default:
                begin
                    min_next = min_reg;
                end
            endcase
            err_next  = is_norm && bounds_equal;
            pout_next = item_reg.pixel_in;
            prod_next = diff_pix * diff_tgt;
            dvsr_next = $signed({1'b0, range_high_reg}) - $signed({1'b0, range_low_reg});
        end

        if (cmd.prep)
        begin
            // signed division done on magnitudes, sign applied at the end
            neg_next = prod_reg[PROD_W-1] ^ dvsr_reg[DIFF_W-1];
            quo_next = prod_abs[MAG_W-1:0];
            den_next = dvsr_abs[PIX_W-1:0];
            rem_next = '0;
            cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            if (!trial_sub[PIX_W])
            begin
                rem_next = trial_sub[PIX_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial_rem[PIX_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (cmd.fix)
        begin
            pout_next = quo_low + target_low_reg;
        end

        if (cmd.load_result)
        begin
            res_next.pixel_out    = pout_reg;
            res_next.bound_min    = min_reg;
            res_next.bound_max    = max_reg;
            res_next.divide_error = err_reg;
            res_valid_next        = 1'b1;
        end
    end

    assign stat.normalize_go = is_norm && !bounds_equal;
    assign stat.div_last     = (cnt_reg == CNT_W'(MAG_W - 1));
    assign stat.res_free     = !res_valid_reg || !res_stall;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

@@ design/cstr_checker.sv @@
// ----------------------------------------------------------------------------
// cstr_checker - port level checks for the contrast stretch block
// bound to the top level
// ----------------------------------------------------------------------------
module cstr_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pix_valid,
    input  logic                       pix_stall,
    input  logic                       res_valid,
    input  logic                       res_stall,
    input  cstr_pkg::res_t             res_data
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    // a stalled result payload holds
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_data))
        else $error("result payload changed while stalled");

    // one transaction at a time: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall |=> pix_stall)
        else $error("second transaction accepted back to back");

    // a new result only appears out of a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_stall))
        else $error("result appeared without work in progress");

endmodule

bind grayscale_min_max_contrast_stretch_top cstr_checker u_cstr_checker (.*);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - regression bench for grayscale_min_max_contrast_stretch_top
// drives clear, measure and normalize transactions under several source and
// target ranges, predicts each result with its own copy of the bounds and
// registers, and compares every returned transaction field by field
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W   = cstr_pkg::PIX_W;
    localparam int PIX_MAX = 2**PIX_W - 1;

    // opcode 3 is not decoded by the block, the bounds must stay put
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // scoreboard: predicted bounds and mapped pixels, queue of awaited results
    // ------------------------------------------------------------------------
    class stretch_tracker;
        logic [PIX_W-1:0] src_low;
        logic [PIX_W-1:0] src_high;
        logic [PIX_W-1:0] dst_low;
        logic [PIX_W-1:0] dst_high;
        logic [PIX_W-1:0] run_min;
        logic [PIX_W-1:0] run_max;
        cstr_pkg::res_t   awaited[$];
        int               mismatches;

        function new();
            src_low    = cstr_pkg::PIX_ZERO;
            src_high   = cstr_pkg::PIX_FULL;
            dst_low    = cstr_pkg::PIX_ZERO;
            dst_high   = cstr_pkg::PIX_FULL;
            run_min    = cstr_pkg::PIX_FULL;
            run_max    = cstr_pkg::PIX_ZERO;
            mismatches = 0;
        endfunction

        function void set_reg(logic [1:0] index, logic [PIX_W-1:0] value);
            case (index)
                cstr_pkg::REG_RANGE_LOW:   src_low  = value;
                cstr_pkg::REG_RANGE_HIGH:  src_high = value;
                cstr_pkg::REG_TARGET_LOW:  dst_low  = value;
                cstr_pkg::REG_TARGET_HIGH: dst_high = value;
                default: ;
            endcase
        endfunction

        // updates the bounds and returns the result this transaction must give
        function cstr_pkg::res_t stretch_result(cstr_pkg::pix_in_t item);
            cstr_pkg::res_t r;
            int   lo;
            int   hi;
            int   tlo;
            int   thi;
            int   num;
            int   q;
            r.pixel_out    = item.pixel_in;
            r.divide_error = 1'b0;
            case (item.opcode)
                cstr_pkg::OP_CLEAR:
                begin
                    run_min = cstr_pkg::PIX_FULL;
                    run_max = cstr_pkg::PIX_ZERO;
                end
                cstr_pkg::OP_MEASURE:
                begin
                    if (item.pixel_in < run_min)
                        run_min = item.pixel_in;
                    if (item.pixel_in > run_max)
                        run_max = item.pixel_in;
                end
                cstr_pkg::OP_NORMALIZE:
                begin
                    lo  = int'(src_low);
                    hi  = int'(src_high);
                    tlo = int'(dst_low);
                    thi = int'(dst_high);
                    if (hi == lo)
                        r.divide_error = 1'b1;
                    else
                    begin
                        // signed divide truncates toward zero, keep low pixel bits
                        num         = (int'(item.pixel_in) - lo) * (thi - tlo);
                        q           = num / (hi - lo) + tlo;
                        r.pixel_out = q[PIX_W-1:0];
                    end
                end
                default: ;
            endcase
            r.bound_min = run_min;
            r.bound_max = run_max;
            return r;
        endfunction

        function void note_pixel(cstr_pkg::pix_in_t item);
            awaited.push_back(stretch_result(item));
        endfunction

        task report(string what);
            $display("%0t ns mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(cstr_pkg::res_t got);
            cstr_pkg::res_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = awaited.pop_front();
            if (got.pixel_out !== want.pixel_out)
                report($sformatf("pixel_out %0d, expected %0d", got.pixel_out, want.pixel_out));
            if (got.bound_min !== want.bound_min)
                report($sformatf("bound_min %0d, expected %0d", got.bound_min, want.bound_min));
            if (got.bound_max !== want.bound_max)
                report($sformatf("bound_max %0d, expected %0d", got.bound_max, want.bound_max));
            if (got.divide_error !== want.divide_error)
                report($sformatf("divide_error %b, expected %b",
                                 got.divide_error, want.divide_error));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              pix_valid;
    logic              pix_stall;
    cstr_pkg::pix_in_t pix_data;
    logic              res_valid;
    logic              res_stall;
    cstr_pkg::res_t    res_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [PIX_W-1:0]  cfg_data;

    // idling odds in percent; a long receiver hold-off requested by the main
    // sequence and counted down in the result process
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_go   = 1'b0;
    int hold_left;

    stretch_tracker tracker = new();

    always #2 clk = ~clk;

    grayscale_min_max_contrast_stretch_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------

    // offer one pixel transaction, with random idle cycles ahead of it
    task automatic send_item(logic [1:0] op, logic [PIX_W-1:0] pixel);
        cstr_pkg::pix_in_t item;
        item.opcode   = op;
        item.pixel_in = pixel;
        while ($urandom_range(99) < idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= item;
        // payload holds until the block takes it
        do @(posedge clk); while (pix_stall !== 1'b0);
        tracker.note_pixel(item);
    endtask

    // stop offering and wait until every awaited result has come back
    task automatic drain();
        pix_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all four range registers back to back, block must be idle
    task automatic load_config(logic [PIX_W-1:0] lo, logic [PIX_W-1:0] hi,
                               logic [PIX_W-1:0] tlo, logic [PIX_W-1:0] thi);
        logic [1:0]       index [4];
        logic [PIX_W-1:0] value [4];
        index = '{cstr_pkg::REG_RANGE_LOW, cstr_pkg::REG_RANGE_HIGH,
                  cstr_pkg::REG_TARGET_LOW, cstr_pkg::REG_TARGET_HIGH};
        value = '{lo, hi, tlo, thi};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= index[i];
            cfg_data  <= value[i];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            tracker.set_reg(index[i], value[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly normalize and measure, with some clears and unused opcodes as noise
    function automatic logic [1:0] mixed_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return cstr_pkg::OP_NORMALIZE;
        else if (pick < 85)
            return cstr_pkg::OP_MEASURE;
        else if (pick < 93)
            return cstr_pkg::OP_CLEAR;
        else
            return OP_UNUSED;
    endfunction

    // the usual stretch flow: clear, measure a frame, map onto the target range
    task automatic stretch_round(int n_measure, int n_mixed,
                                 logic [PIX_W-1:0] tlo, logic [PIX_W-1:0] thi);
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        send_item(cstr_pkg::OP_CLEAR, PIX_W'($urandom_range(PIX_MAX)));
        repeat (n_measure)
            send_item(cstr_pkg::OP_MEASURE, PIX_W'($urandom_range(PIX_MAX)));
        drain();
        if ($urandom_range(9) < 7)
        begin
            // source range from the measured bounds
            lo = tracker.run_min;
            hi = tracker.run_max;
        end
        else
        begin
            // arbitrary source range, sometimes degenerate
            lo = PIX_W'($urandom_range(PIX_MAX));
            hi = ($urandom_range(3) == 0) ? lo : PIX_W'($urandom_range(PIX_MAX));
        end
        load_config(lo, hi, tlo, thi);
        repeat (n_mixed)
            send_item(mixed_op(), PIX_W'($urandom_range(PIX_MAX)));
    endtask

    // ------------------------------------------------------------------------
    // result side: check accepted transactions, then pick the next stall
    // ------------------------------------------------------------------------
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        hold_left  = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid === 1'b1 && res_stall === 1'b0)
                tracker.check_result(res_data);
            if (hold_go && !hold_taken)
            begin
                hold_left  = 200;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                // long hold-off so the block backs up into its input
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int               idle_of [4];
        int               stall_of [4];
        logic [PIX_W-1:0] tlo;
        logic [PIX_W-1:0] thi;

        // phases: no idling, sender idle, receiver stalling, both
        idle_of  = '{0, 52, 0, 37};
        stall_of = '{0, 0, 52, 37};

        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= cstr_pkg::REG_RANGE_LOW;
        cfg_data  <= cstr_pkg::PIX_ZERO;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset ranges map identity; bounds still empty for the first normalize
        send_item(cstr_pkg::OP_NORMALIZE, 8'd0);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd255);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd128);
        send_item(cstr_pkg::OP_MEASURE, 8'h55);
        send_item(cstr_pkg::OP_MEASURE, 8'hAA);
        send_item(cstr_pkg::OP_MEASURE, 8'd0);
        send_item(cstr_pkg::OP_MEASURE, 8'd255);
        // unused opcode leaves bounds alone and echoes the pixel
        send_item(OP_UNUSED, 8'h3C);
        send_item(cstr_pkg::OP_CLEAR, 8'hFF);
        send_item(cstr_pkg::OP_CLEAR, 8'h00);
        // single sample, min equals max
        send_item(cstr_pkg::OP_MEASURE, 8'd77);
        drain();

        // equal source bounds: pass through with the error flag
        load_config(8'd100, 8'd100, 8'd0, 8'd255);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd100);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd255);
        drain();

        // reversed source range
        load_config(8'd255, 8'd0, 8'd0, 8'd255);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd0);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd255);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd100);
        drain();

        // reversed target range, pixels outside the source range
        load_config(8'd10, 8'd200, 8'd255, 8'd0);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd0);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd255);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd105);
        drain();

        // narrowest source range, quotient far beyond a pixel and wraps
        load_config(8'd0, 8'd1, 8'd0, 8'd255);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd255);
        send_item(cstr_pkg::OP_NORMALIZE, 8'd1);
        drain();

        // random rounds under each idling mix, extreme targets first and last
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_of[p];
            stall_pct = stall_of[p];
            for (int r = 0; r < 3; r++)
            begin
                if (p == 0)
                begin
                    tlo = cstr_pkg::PIX_ZERO;
                    thi = cstr_pkg::PIX_FULL;
                end
                else if (p == 3)
                begin
                    tlo = cstr_pkg::PIX_FULL;
                    thi = cstr_pkg::PIX_ZERO;
                end
                else
                begin
                    tlo = PIX_W'($urandom_range(PIX_MAX));
                    thi = PIX_W'($urandom_range(PIX_MAX));
                end
                stretch_round($urandom_range(4, 14), $urandom_range(14, 22), tlo, thi);
            end
            drain();
        end

        // receiver holds off while the sender keeps offering transactions
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b1;
        repeat (40)
            send_item(mixed_op(), PIX_W'($urandom_range(PIX_MAX)));
        drain();

        // let any late transaction surface before the verdict
        repeat (30) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("grayscale_min_max_contrast_stretch_top regression: pass");
        else
            $display("grayscale_min_max_contrast_stretch_top regression: fail");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #2_000_000;
        $display("grayscale_min_max_contrast_stretch_top regression: fail");
        $finish;
    end

endmodule
